### hdl/srw_pkg.sv
// Shared constants, control types and a helper function for the sign ring window response block.
package srw_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_TEMPLATE = 16;
  localparam int TIDX_W = $clog2(MAX_TEMPLATE);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ADDR_W = TIDX_W + COL_W;
  localparam int ACC_W  = 21;   // signed weighted sum
  localparam int DVD_W  = 20;   // magnitude of a nonnegative sum
  localparam int DVS_W  = 9;    // (T-2C)*4B
  localparam int REM_W  = DVS_W + 1;
  localparam int DCNT_W = 5;

  localparam logic [2:0] CFG_TEMPLATE = 3'd0;
  localparam logic [2:0] CFG_BOX      = 3'd1;
  localparam logic [2:0] CFG_CORNER   = 3'd2;
  localparam logic [2:0] CFG_WIDTH    = 3'd3;
  localparam logic [2:0] CFG_HEIGHT   = 3'd4;

  typedef struct packed {
    logic accept;
    logic scan;
    logic div_init;
    logic div_step;
    logic load_out;
  } srw_cmd_t;

  typedef struct packed {
    logic win_valid;
    logic scan_last;
    logic div_last;
    logic out_free;
  } srw_sts_t;

  // weight of one band set: -1 outer band, +mid inner band, -1 third band
  function automatic logic signed [4:0] band_coef(input logic [4:0] v, input logic [2:0] b,
                                                  input logic [1:0] mid);
    logic [4:0] b1;
    logic [4:0] b2;
    logic [4:0] b3;
    begin
      b1 = {2'b00, b};
      b2 = b1 << 1;
      b3 = b1 + b2;
      if (v < b1) band_coef = -5'sd1;
      else if (v < b2) band_coef = $signed({3'b000, mid});
      else if (v < b3) band_coef = -5'sd1;
      else band_coef = 5'sd0;
    end
  endfunction

endpackage

### hdl/sign_ring_window_response.sv
// An item that completes no window is stored and counted; one that completes a window gives
// its result after T*T line store reads, a flush state, a divider load, 20 divider steps and
// the output load, which waits while m_tready is low. One item is taken per cycle while none
// completes a window; after one that does, no item is taken until its result is loaded.
// Reset (rst, synchronous, active high) restores default settings and clears position
// counters and handshake state; the line store is not cleared.
module sign_ring_window_response
  import srw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] pixel
  input  logic        s_tuser,   // [0] frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [5:0] response, [13:6] corner_col, [21:14] corner_row
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  srw_cmd_t cmd;
  srw_sts_t sts;

  srw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  srw_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### hdl/srw_ctrl.sv
// Controller: sequences accept, window scan, division and result hand-off.
module srw_ctrl
  import srw_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  srw_sts_t sts,
  output srw_cmd_t cmd
);

  typedef enum logic [2:0] {IDLE, SCAN, FLUSH, DINIT, DIV, PUT} state_t;
  state_t state;

  assign s_tready = (state == IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      IDLE:    cmd.accept   = s_tvalid;
      SCAN:    cmd.scan     = 1'b1;
      DINIT:   cmd.div_init = 1'b1;
      DIV:     cmd.div_step = 1'b1;
      PUT:     cmd.load_out = sts.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE:    if (s_tvalid && sts.win_valid) state <= SCAN;
        SCAN:    if (sts.scan_last) state <= FLUSH;
        FLUSH:   state <= DINIT;
        DINIT:   state <= DIV;
        DIV:     if (sts.div_last) state <= PUT;
        PUT:     if (sts.out_free) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

endmodule

### hdl/srw_dp.sv
// Datapath: config, position counters, line store, weighted sum, divider, output register.
module srw_dp
  import srw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  srw_cmd_t    cmd,
  output srw_sts_t    sts
);

  logic [4:0] t_raw;
  logic [2:0] b_raw;
  logic [2:0] c_raw;
  logic [8:0] w_raw;
  logic [8:0] h_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_raw <= 5'd6;
      b_raw <= 3'd1;
      c_raw <= 3'd2;
      w_raw <= 9'd160;
      h_raw <= 9'd120;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEMPLATE: t_raw <= cfg_data[4:0];
        CFG_BOX:      b_raw <= cfg_data[2:0];
        CFG_CORNER:   c_raw <= cfg_data[2:0];
        CFG_WIDTH:    w_raw <= cfg_data;
        CFG_HEIGHT:   h_raw <= cfg_data;
        default:      ;
      endcase
    end
  end

  // effective settings after clamping
  logic [4:0] t_e;
  logic [2:0] b_e;
  logic [2:0] c_e;
  logic [8:0] w_e;
  logic [8:0] h_e;
  logic [8:0] tm1_x11;
  logic [2:0] b_min;

  always_comb begin
    t_e = t_raw;
    if (t_e < 5'd6) t_e = 5'd6;
    if (t_e > 5'(MAX_TEMPLATE)) t_e = 5'(MAX_TEMPLATE);
    tm1_x11 = 9'({4'd0, t_e - 5'd1} * 9'd11);   // (t-1)/3 for t up to 16
    b_min = (b_raw == 3'd0) ? 3'd1 : b_raw;
    b_e = ((6'({3'd0, b_min}) * 6'd3 + 6'd1) > {1'b0, t_e}) ? tm1_x11[7:5] : b_min;
    c_e = ({1'b0, c_raw, 1'b0} >= t_e) ? 3'((t_e - 5'd1) >> 1) : c_raw;
    w_e = w_raw;
    if (w_e < 9'd17) w_e = 9'd17;
    if (w_e > 9'(MAX_WIDTH)) w_e = 9'(MAX_WIDTH);
    h_e = h_raw;
    if (h_e < 9'd17) h_e = 9'd17;
    if (h_e > 9'd256) h_e = 9'd256;
  end

  // position of the incoming item
  logic [7:0] col_count;
  logic [7:0] row_count;
  logic [8:0] c0;
  logic [8:0] r0;
  logic [8:0] cn;
  logic [8:0] rn;
  logic [8:0] c1;
  logic [8:0] r1;
  logic       win_ok;

  always_comb begin
    c0 = s_tuser ? 9'd0 : {1'b0, col_count};
    r0 = s_tuser ? 9'd0 : {1'b0, row_count};
    if (c0 >= w_e) begin
      c0 = 9'd0;
      r0 = r0 + 9'd1;
    end
    if (r0 >= h_e) r0 = 9'd0;
    c1 = c0 + 9'd1;
    r1 = r0 + 9'd1;
    cn = c1;
    rn = r0;
    if (cn >= w_e) begin
      cn = 9'd0;
      rn = r1;
      if (rn >= h_e) rn = 9'd0;
    end
    win_ok = (c1 >= {4'd0, t_e}) && (r1 >= {4'd0, t_e}) && (c1 < w_e) && (r1 < h_e);
  end

  logic [7:0] xs;
  logic [7:0] ys;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (cmd.accept) begin
      col_count <= cn[7:0];
      row_count <= rn[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      xs <= 8'(c1 - {4'd0, t_e});
      ys <= 8'(r1 - {4'd0, t_e});
    end
  end

  // window scan counters
  logic [TIDX_W-1:0] sr;
  logic [TIDX_W-1:0] sc;
  logic [TIDX_W-1:0] tlast;
  logic              row_end;

  assign tlast   = TIDX_W'(t_e - 5'd1);
  assign row_end = (sc == tlast);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sr <= '0;
      sc <= '0;
    end else if (cmd.scan) begin
      if (row_end) begin
        sc <= '0;
        sr <= sr + 1'b1;
      end else begin
        sc <= sc + 1'b1;
      end
    end
  end

  // line store: one write on accept, one read per scan cycle
  logic [7:0]        mem [0:(1 << ADDR_W)-1];
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        pix_q;

  assign waddr = {r0[TIDX_W-1:0], c0[COL_W-1:0]};
  assign raddr = {ys[TIDX_W-1:0] + sr, xs + COL_W'(sc)};

  always_ff @(posedge clk) begin
    if (cmd.accept) mem[waddr] <= s_tdata;
    pix_q <= mem[raddr];
  end

  // per-pixel weight
  logic [4:0]        r5;
  logic [4:0]        c5;
  logic signed [4:0] coef;

  always_comb begin
    r5 = {1'b0, sr};
    c5 = {1'b0, sc};
    coef = 5'sd0;
    if (r5 >= {2'b00, c_e} && r5 < t_e - {2'b00, c_e})
      coef = coef + band_coef(c5, b_e, 2'd2) + band_coef(t_e - 5'd1 - c5, b_e, 2'd2);
    if (c5 >= {2'b00, c_e} && c5 < t_e - {2'b00, c_e})
      coef = coef + band_coef(r5, b_e, 2'd3) + band_coef(t_e - 5'd1 - r5, b_e, 2'd3);
  end

  logic signed [4:0]      coef_q;
  logic                   first_q;
  logic                   v_q;
  logic signed [13:0]     prod;
  logic signed [ACC_W-1:0] acc;
  logic                   zero_corner;

  assign prod = $signed({1'b0, pix_q}) * coef_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= 1'b0;
    end else begin
      v_q <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    coef_q  <= coef;
    first_q <= (sr == '0) && (sc == '0);
    if (cmd.accept) acc <= '0;
    else if (v_q) acc <= acc + ACC_W'(prod);
    if (v_q && first_q) zero_corner <= (pix_q == 8'd0);
  end

  // restoring divider, one quotient bit a cycle
  logic [DVS_W-1:0]  dvs;
  logic [DVD_W-1:0]  quo;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_s;
  logic              ge;
  logic [DCNT_W-1:0] dcnt;

  assign dvs   = DVS_W'(({4'd0, t_e} - {5'd0, c_e, 1'b0}) * {6'd0, b_e} * 9'd4);
  assign rem_s = {rem[REM_W-2:0], quo[DVD_W-1]};
  assign ge    = (rem_s >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo  <= acc[ACC_W-1] ? '0 : acc[DVD_W-1:0];
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      rem  <= ge ? rem_s - {1'b0, dvs} : rem_s;
      quo  <= {quo[DVD_W-2:0], ge};
      dcnt <= dcnt + 1'b1;
    end
  end

  // divide by ten: x*205 >> 11 is exact below 1029
  logic [9:0]  q10;
  logic [17:0] q205;
  logic [5:0]  resp;

  assign q10  = (|quo[DVD_W-1:10]) ? 10'h3ff : quo[9:0];
  assign q205 = {8'd0, q10} * 18'd205;
  assign resp = zero_corner ? 6'd0 : q205[16:11];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) m_tdata <= {2'b00, ys, xs, resp};
  end

  assign sts.win_valid = win_ok;
  assign sts.scan_last = row_end && (sr == tlast);
  assign sts.div_last  = (dcnt == DCNT_W'(DVD_W - 1));
  assign sts.out_free  = !m_tvalid || m_tready;

endmodule
